// ===== src/bba_pkg.sv =====
`default_nettype none
package bba_pkg;
  typedef enum logic [1:0] {
    ST_UNUSED = 2'd0,
    ST_FREE   = 2'd1,
    ST_SPLIT  = 2'd2,
    ST_ALLOC  = 2'd3
  } node_st_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NO_FREE   = 2'd1,
    STS_TOO_LARGE = 2'd2,
    STS_BAD_FREE  = 2'd3
  } status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
endpackage
`default_nettype wire

// ===== src/bba_ram.sv =====
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/buddy_block_allocator.sv =====
// channel  | signals                                   | dir
// command  | start, busy, opcode, request_size, block_offset | in (busy is out)
// result   | done, status, grant_offset, grant_size    | out
// a word is taken when start is high and busy is low; busy stays high until done
// done pulses for one cycle with the result; the receiver cannot stall it
// after rst a clearing pass writes every tree node with busy high
// allocate: depth-first scan that reads each node and steps past a used node or climbs a
// level, then splits down to the target level, writing the node and both of its children
// free: descent from the root, then merges with a free buddy upward level by level
`default_nettype none
module buddy_block_allocator #(
  parameter int TOTAL_UNITS = 2048,
  parameter int MIN_BLOCK   = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        opcode,
  input  wire logic [11:0] request_size,
  input  wire logic [10:0] block_offset,
  output logic             done,
  output logic [1:0]       status,
  output logic [10:0]      grant_offset,
  output logic [11:0]      grant_size
);
  localparam int LEAVES     = TOTAL_UNITS / MIN_BLOCK;
  localparam int NODE_SLOTS = 2 * LEAVES;
  localparam int AW         = $clog2(NODE_SLOTS);
  localparam int LW         = $clog2($clog2(LEAVES) + 2);
  localparam int LEVELS     = $clog2(LEAVES);
  localparam int SW         = $clog2(TOTAL_UNITS) + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_RD, S_A_EV, S_A_UP, S_A_SPLIT, S_A_SPLIT2, S_A_SPLIT3,
    S_F_RD, S_F_EV, S_M_RD, S_M_EV, S_M_WR, S_M_WR2, S_DONE
  } state_t;

  state_t           state;
  logic [AW-1:0]    node;
  logic [LW-1:0]    lvl;
  logic [LW-1:0]    tlvl;
  logic [AW:0]      clr;
  logic [SW-1:0]    off;
  logic [1:0]       sts;
  logic [SW-1:0]    res_off;
  logic [SW-1:0]    res_size;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [1:0]       wdata;
  logic [AW-1:0]    raddr;
  logic [1:0]       rdata;

  bba_ram #(.WIDTH(2), .DEPTH(NODE_SLOTS)) u_tree (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // size of a node at level l is TOTAL_UNITS >> l
  function automatic logic [SW-1:0] lsize(input logic [LW-1:0] l);
    lsize = SW'(TOTAL_UNITS) >> l;
  endfunction

  // target level: deepest level whose size still covers the request
  logic [LW-1:0] req_lvl;
  always_comb begin
    req_lvl = '0;
    for (int k = 1; k <= LEVELS; k++) begin
      if (({20'd0, request_size} <= 32'(TOTAL_UNITS >> k))) begin
        req_lvl = LW'(k);
      end
    end
  end

  logic [SW-1:0] node_off;
  logic [SW-1:0] node_sz;
  logic          is_last_sibling;
  assign node_sz  = lsize(lvl);
  // offset: index within level times size
  assign node_off = SW'((32'(node) - (32'd1 << lvl)) * 32'(node_sz));
  assign is_last_sibling = node[0];

  assign raddr = node;
  assign busy  = (state != S_IDLE);

  always_comb begin
    we = 1'b0;
    waddr = node;
    wdata = bba_pkg::ST_UNUSED;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr[AW-1:0];
        wdata = (clr == (AW+1)'(1)) ? bba_pkg::ST_FREE : bba_pkg::ST_UNUSED;
      end
      S_A_SPLIT: begin
        we = 1'b1;
        wdata = (lvl == tlvl) ? bba_pkg::ST_ALLOC : bba_pkg::ST_SPLIT;
      end
      S_A_SPLIT2: begin
        we = 1'b1;
        waddr = {node[AW-2:0], 1'b0};
        wdata = bba_pkg::ST_FREE;
      end
      S_A_SPLIT3: begin
        we = 1'b1;
        waddr = {node[AW-2:0], 1'b1};
        wdata = bba_pkg::ST_FREE;
      end
      S_F_EV: begin
        we = (rdata == bba_pkg::ST_ALLOC) && (node_off == off);
        wdata = bba_pkg::ST_FREE;
      end
      S_M_EV: begin
        // node holds the buddy; merge both into the parent when it is free
        we = (rdata == bba_pkg::ST_FREE);
        wdata = bba_pkg::ST_UNUSED;
      end
      S_M_WR: begin
        we = 1'b1;
        waddr = node ^ AW'(1);
        wdata = bba_pkg::ST_UNUSED;
      end
      S_M_WR2: begin
        we = 1'b1;
        waddr = node >> 1;
        wdata = bba_pkg::ST_FREE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(NODE_SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            off  <= SW'(block_offset);
            node <= AW'(1);
            lvl  <= '0;
            tlvl <= req_lvl;
            res_off  <= '0;
            res_size <= '0;
            if (opcode == bba_pkg::OP_FREE) begin
              state <= S_F_RD;
            end else if ({20'd0, request_size} > 32'(TOTAL_UNITS)) begin
              sts   <= bba_pkg::STS_TOO_LARGE;
              state <= S_DONE;
            end else begin
              state <= S_A_RD;
            end
          end
        end
        S_A_RD: state <= S_A_EV;
        S_A_EV: begin
          // depth-first in address order, never below target level
          if (rdata == bba_pkg::ST_FREE) begin
            res_off <= node_off;
            state   <= S_A_SPLIT;
          end else if (rdata == bba_pkg::ST_SPLIT && lvl < tlvl) begin
            node  <= {node[AW-2:0], 1'b0};
            lvl   <= lvl + 1'b1;
            state <= S_A_RD;
          end else begin
            state <= S_A_UP;
          end
        end
        S_A_UP: begin
          // advance to next sibling, climbing past right children
          priority if (node == AW'(1)) begin
            sts <= bba_pkg::STS_NO_FREE;
            state <= S_DONE;
          end else if (!is_last_sibling) begin
            node  <= node + 1'b1;
            state <= S_A_RD;
          end else begin
            node  <= node >> 1;
            lvl   <= lvl - 1'b1;
          end
        end
        S_A_SPLIT: begin
          if (lvl == tlvl) begin
            sts      <= bba_pkg::STS_OK;
            res_size <= node_sz;
            state    <= S_DONE;
          end else begin
            state <= S_A_SPLIT2;
          end
        end
        S_A_SPLIT2: state <= S_A_SPLIT3;
        S_A_SPLIT3: begin
          node  <= {node[AW-2:0], 1'b0};
          lvl   <= lvl + 1'b1;
          state <= S_A_SPLIT;
        end
        S_F_RD: state <= S_F_EV;
        S_F_EV: begin
          if (rdata == bba_pkg::ST_ALLOC && node_off == off) begin
            res_off  <= off;
            res_size <= node_sz;
            sts      <= bba_pkg::STS_OK;
            if (node == AW'(1)) begin
              state <= S_DONE;
            end else begin
              node  <= node ^ AW'(1);
              state <= S_M_RD;
            end
          end else if (rdata == bba_pkg::ST_SPLIT && 32'(lvl) < LEVELS) begin
            lvl  <= lvl + 1'b1;
            node <= ((off - node_off) >= (node_sz >> 1)) ?
                    {node[AW-2:0], 1'b1} : {node[AW-2:0], 1'b0};
            state <= S_F_RD;
          end else begin
            sts   <= bba_pkg::STS_BAD_FREE;
            state <= S_DONE;
          end
        end
        S_M_RD: state <= S_M_EV;
        S_M_EV: begin
          state <= (rdata == bba_pkg::ST_FREE) ? S_M_WR : S_DONE;
        end
        S_M_WR: state <= S_M_WR2;
        S_M_WR2: begin
          if ((node >> 1) == AW'(1)) begin
            state <= S_DONE;
          end else begin
            node  <= (node >> 1) ^ AW'(1);
            state <= S_M_RD;
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      status       <= sts;
      grant_offset <= (sts == bba_pkg::STS_OK) ? res_off[10:0] : 11'd0;
      grant_size   <= (sts == bba_pkg::STS_OK) ? 12'(res_size) : 12'd0;
    end
  end
endmodule
`default_nettype wire

// ===== src/bba_checker.sv =====
`default_nettype none
module bba_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [1:0]  status,
  input wire logic [10:0] grant_offset,
  input wire logic [11:0] grant_size
);
  // a result never follows a result directly
  a_done_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("back to back results");
  // the block is free again when a result shows
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("busy during result");
  // errors carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != bba_pkg::STS_OK |-> grant_offset == 11'd0 && grant_size == 12'd0)
    else $error("error result with nonzero fields");
  // a word taken makes the block busy
  a_take: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("word taken but not busy");
endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .grant_offset(grant_offset), .grant_size(grant_size)
);
`default_nettype wire
